// File: sv/ecw_pkg.sv
package ecw_pkg;

	localparam int WINDOW_BITS = 16;
	localparam int RTT_BITS    = 24;
	localparam int CREDIT_BITS = 24;
	localparam int WEIGHT_BITS = 20;
	localparam int CFG_BITS    = 16;
	localparam int CFG_IDX_BITS = 2;

	localparam int DIV_W      = RTT_BITS + WINDOW_BITS;
	localparam int DIV_STEPS  = DIV_W;
	localparam int SQRT_STEPS = DIV_W / 2;
	localparam int ROOT_W     = DIV_W / 2;
	localparam int SQR_W      = ROOT_W + 2;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	localparam logic [WINDOW_BITS-1:0] WINDOW_RESET    = WINDOW_BITS'(2);
	localparam logic [WINDOW_BITS-1:0] THRESHOLD_RESET = '1;
	localparam logic [WINDOW_BITS-1:0] CLAMP_RESET     = '1;

	localparam logic [1:0] OP_ACK     = 2'd0;
	localparam logic [1:0] OP_LOSS    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;
	// The last code is unassigned; such a beat leaves all state alone.
	localparam logic [1:0] OP_NONE    = 2'd3;

	localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_WINDOW    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_CLAMP      = 2'd2;

	typedef struct packed {
		logic [1:0]          operation;
		logic                sample_valid;
		logic [RTT_BITS-1:0] rtt_us;
	} in_item_t;

	typedef struct packed {
		logic [WINDOW_BITS-1:0] window;
		logic [WINDOW_BITS-1:0] threshold;
		logic [WEIGHT_BITS-1:0] weight_factor;
		logic [RTT_BITS-1:0]    base_delay;
		logic [RTT_BITS-1:0]    peak_delay;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_DIV,
		ST_SQRT,
		ST_ADD,
		ST_GROW,
		ST_MOD_LOAD,
		ST_MOD_DIV,
		ST_MOD_SET,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic mul;
		logic div_step;
		logic sqrt_step;
		logic add;
		logic grow_step;
		logic mod_load;
		logic mod_set;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic ca;
		logic seen;
		logic div_last;
		logic sqrt_last;
		logic grow_more;
		logic need_mod;
	} status_t;

endpackage

// File: sv/ecw_datapath.sv
module ecw_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ecw_pkg::cmd_t                        cmd,
	output ecw_pkg::status_t                     sts,
	input  ecw_pkg::in_item_t                    in_data,
	input  logic                                 cfg_we,
	input  logic [ecw_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [ecw_pkg::CFG_BITS-1:0]         cfg_data,
	output ecw_pkg::out_item_t                   out_data
);

	localparam int WB = ecw_pkg::WINDOW_BITS;
	localparam int RB = ecw_pkg::RTT_BITS;
	localparam int CB = ecw_pkg::CREDIT_BITS;
	localparam int DW = ecw_pkg::DIV_W;
	localparam int RW = ecw_pkg::ROOT_W;
	localparam int SW = ecw_pkg::SQR_W;

	logic [WB-1:0] clamp_q;
	logic [1:0]    op_q;
	logic          sv_q;
	logic [RB-1:0] rtt_q;
	logic [RB-1:0] base_q, peak_q, latest_q;
	logic          seen_q;
	logic [WB-1:0] cwnd_q, ssth_q;
	logic [CB-1:0] credit_q;
	logic [ecw_pkg::WEIGHT_BITS-1:0] weight_q;
	logic [DW-1:0] num_q;
	logic [RB-1:0] den_q, rem_q;
	logic [SW-1:0] sqrem_q;
	logic [RW-1:0] root_q;
	logic [ecw_pkg::CNT_W-1:0] cnt_q;
	ecw_pkg::out_item_t out_q;

	logic [RB-1:0] sample;
	logic [RB:0]   rem_sh;
	logic          rem_ge;
	logic [SW+1:0] sq_sh, sq_trial;
	logic          sq_ge;
	logic [WB+2:0] loss_t7;
	logic [WB-1:0] loss_thr;
	logic [WB:0]   loss_win;
	logic [CB:0]   credit_sum;
	logic          credit_ge;

	// A sample is held as sample+1, saturating at all ones.
	assign sample = (rtt_q == '1) ? rtt_q : rtt_q + RB'(1);

	assign rem_sh = {rem_q, num_q[DW-1]};
	assign rem_ge = rem_sh >= {1'b0, den_q};

	assign sq_sh    = {sqrem_q, num_q[DW-1:DW-2]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_ge    = sq_sh >= sq_trial;

	assign loss_t7  = {cwnd_q, 3'b000} - {3'b000, cwnd_q};
	assign loss_thr = (loss_t7[WB+2:3] >= WB'(3)) ? loss_t7[WB+2:3] - WB'(1) : WB'(2);
	assign loss_win = {1'b0, loss_thr} + (WB+1)'(1);

	assign credit_sum = {1'b0, credit_q} + (CB+1)'(weight_q);
	assign credit_ge  = credit_q >= CB'(cwnd_q);

	assign sts.ca        = (op_q == ecw_pkg::OP_ACK) && (cwnd_q > ssth_q);
	assign sts.seen      = seen_q;
	assign sts.div_last  = cnt_q == ecw_pkg::CNT_W'(ecw_pkg::DIV_STEPS - 1);
	assign sts.sqrt_last = cnt_q == ecw_pkg::CNT_W'(ecw_pkg::SQRT_STEPS - 1);
	assign sts.grow_more = (cwnd_q < clamp_q) && credit_ge;
	assign sts.need_mod  = credit_ge;

	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_q  <= ecw_pkg::CLAMP_RESET;
			base_q   <= '1;
			peak_q   <= '0;
			latest_q <= '0;
			seen_q   <= 1'b0;
			cwnd_q   <= ecw_pkg::WINDOW_RESET;
			ssth_q   <= ecw_pkg::THRESHOLD_RESET;
			credit_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (cfg_we && cfg_index == ecw_pkg::REG_WINDOW_CLAMP) begin
				clamp_q <= cfg_data;
			end
			if (cmd.decode) begin
				case (op_q)
					ecw_pkg::OP_ACK: begin
						if (sv_q) begin
							if (sample < base_q) base_q <= sample;
							if (sample > peak_q) peak_q <= sample;
							latest_q <= sample;
							seen_q   <= 1'b1;
						end
						if (cwnd_q <= ssth_q && cwnd_q < clamp_q) begin
							cwnd_q <= cwnd_q + WB'(1);
						end
					end
					ecw_pkg::OP_LOSS: begin
						ssth_q <= loss_thr;
						cwnd_q <= (loss_win > {1'b0, clamp_q}) ? clamp_q : loss_win[WB-1:0];
					end
					ecw_pkg::OP_RESTART: begin
						base_q <= '1;
						peak_q <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.mul) cnt_q <= '0;
			if (cmd.mod_load) cnt_q <= '0;
			if (cmd.div_step) cnt_q <= sts.div_last ? '0 : cnt_q + ecw_pkg::CNT_W'(1);
			if (cmd.sqrt_step) cnt_q <= sts.sqrt_last ? '0 : cnt_q + ecw_pkg::CNT_W'(1);
			if (cmd.add) credit_q <= credit_sum[CB] ? '1 : credit_sum[CB-1:0];
			if (cmd.grow_step && sts.grow_more) begin
				credit_q <= credit_q - CB'(cwnd_q);
				cwnd_q   <= cwnd_q + WB'(1);
			end
			if (cmd.mod_set) credit_q <= CB'(rem_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_data.operation;
			sv_q  <= in_data.sample_valid;
			rtt_q <= in_data.rtt_us;
		end
		if (cmd.decode) weight_q <= '0;
		if (cmd.mul) begin
			if (seen_q) begin
				num_q <= DW'(peak_q) * DW'(cwnd_q);
			end else begin
				weight_q <= ecw_pkg::WEIGHT_BITS'(1);
			end
			den_q   <= (latest_q == '0) ? RB'(1) : latest_q;
			rem_q   <= '0;
			sqrem_q <= '0;
			root_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? RB'(rem_sh - {1'b0, den_q}) : rem_sh[RB-1:0];
			num_q <= {num_q[DW-2:0], rem_ge};
		end
		if (cmd.sqrt_step) begin
			sqrem_q <= sq_ge ? SW'(sq_sh - sq_trial) : sq_sh[SW-1:0];
			root_q  <= {root_q[RW-2:0], sq_ge};
			num_q   <= {num_q[DW-3:0], 2'b00};
			if (sts.sqrt_last) weight_q <= ecw_pkg::WEIGHT_BITS'({root_q[RW-2:0], sq_ge});
		end
		if (cmd.mod_load) begin
			num_q <= DW'(credit_q);
			den_q <= RB'(cwnd_q);
			rem_q <= '0;
		end
		if (cmd.emit) begin
			out_q.window        <= cwnd_q;
			out_q.threshold     <= ssth_q;
			out_q.weight_factor <= weight_q;
			out_q.base_delay    <= base_q;
			out_q.peak_delay    <= peak_q;
		end
	end

endmodule

// File: sv/ecw_controller.sv
module ecw_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ecw_pkg::status_t  sts,
	output ecw_pkg::cmd_t     cmd
);

	ecw_pkg::state_t state_q, state_next;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == ecw_pkg::ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ecw_pkg::ST_IDLE:     if (in_valid) state_next = ecw_pkg::ST_DECODE;
			ecw_pkg::ST_DECODE:   state_next = sts.ca ? ecw_pkg::ST_MUL : ecw_pkg::ST_DONE;
			ecw_pkg::ST_MUL:      state_next = sts.seen ? ecw_pkg::ST_DIV : ecw_pkg::ST_ADD;
			ecw_pkg::ST_DIV:      if (sts.div_last) state_next = ecw_pkg::ST_SQRT;
			ecw_pkg::ST_SQRT:     if (sts.sqrt_last) state_next = ecw_pkg::ST_ADD;
			ecw_pkg::ST_ADD:      state_next = ecw_pkg::ST_GROW;
			ecw_pkg::ST_GROW: begin
				if (!sts.grow_more) begin
					state_next = sts.need_mod ? ecw_pkg::ST_MOD_LOAD : ecw_pkg::ST_DONE;
				end
			end
			ecw_pkg::ST_MOD_LOAD: state_next = ecw_pkg::ST_MOD_DIV;
			ecw_pkg::ST_MOD_DIV:  if (sts.div_last) state_next = ecw_pkg::ST_MOD_SET;
			ecw_pkg::ST_MOD_SET:  state_next = ecw_pkg::ST_DONE;
			ecw_pkg::ST_DONE:     if (out_free) state_next = ecw_pkg::ST_IDLE;
			default:              state_next = ecw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ecw_pkg::ST_IDLE:     cmd.load = in_valid;
			ecw_pkg::ST_DECODE:   cmd.decode = 1'b1;
			ecw_pkg::ST_MUL:      cmd.mul = 1'b1;
			ecw_pkg::ST_DIV:      cmd.div_step = 1'b1;
			ecw_pkg::ST_SQRT:     cmd.sqrt_step = 1'b1;
			ecw_pkg::ST_ADD:      cmd.add = 1'b1;
			ecw_pkg::ST_GROW:     cmd.grow_step = 1'b1;
			ecw_pkg::ST_MOD_LOAD: cmd.mod_load = 1'b1;
			ecw_pkg::ST_MOD_DIV:  cmd.div_step = 1'b1;
			ecw_pkg::ST_MOD_SET:  cmd.mod_set = 1'b1;
			ecw_pkg::ST_DONE:     cmd.emit = out_free;
			default:              cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ecw_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/elastic_congestion_window.sv
// Loss, restart and slow start beats go from accept through decode straight to the result.
// Congestion avoidance with a sample runs a 40-step divider and a 20-step root,
// then adds one segment per grow step, and reduces the credit modulo the window at the clamp.
// Throughput: one beat in flight; the next is taken as soon as a result is registered.
// Reset: window 2, threshold and clamp 65535, base delay all ones, peak and credit zero.
module elastic_congestion_window (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  ecw_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output ecw_pkg::out_item_t                out_data,
	input  logic                              cfg_we,
	input  logic [ecw_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [ecw_pkg::CFG_BITS-1:0]      cfg_data
);

	ecw_pkg::cmd_t    cmd;
	ecw_pkg::status_t sts;

	ecw_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ecw_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

	// The engine holds one beat at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a beat is in progress");

	// A new result only appears at the end of a beat's processing.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised without a beat in progress");

	// Loading the datapath only happens on an accepted beat.
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (in_valid && in_ready))
		else $error("datapath loaded without an accepted beat");

endmodule

// File: dv/tb_elastic_congestion_window.sv
module tb_elastic_congestion_window;
	timeunit 1ns;
	timeprecision 1ps;

	// Tracks the expected window and delay state and checks every result beat.
	class window_scoreboard;
		bit [15:0] init_window, init_threshold, clamp;
		bit [23:0] base_rtt, peak_rtt, latest_rtt, credit;
		bit        sample_seen;
		bit [15:0] cwnd, ssthresh;
		ecw_pkg::out_item_t pending[$];
		int        errors;

		function new();
			init_window = 16'd2;
			init_threshold = 16'hFFFF;
			clamp = 16'hFFFF;
			base_rtt = 24'hFFFFFF;
			peak_rtt = '0;
			latest_rtt = '0;
			credit = '0;
			sample_seen = 1'b0;
			cwnd = 16'd2;
			ssthresh = 16'hFFFF;
			errors = 0;
		endfunction

		// Register writes only matter for the clamp once out of reset.
		function void write_reg(logic [ecw_pkg::CFG_IDX_BITS-1:0] idx, bit [15:0] value);
			case (idx)
				ecw_pkg::REG_INITIAL_WINDOW:    init_window = value;
				ecw_pkg::REG_INITIAL_THRESHOLD: init_threshold = value;
				ecw_pkg::REG_WINDOW_CLAMP:      clamp = value;
				default: ;
			endcase
		endfunction

		function bit [63:0] int_root(bit [63:0] v);
			bit [63:0] res, b;
			res = '0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function void note(ecw_pkg::in_item_t x);
			bit [63:0] w, c, t, d, win;
			ecw_pkg::out_item_t e;
			w = '0;
			case (x.operation)
				ecw_pkg::OP_ACK: begin
					if (x.sample_valid) begin
						t = 64'(x.rtt_us) + 64'd1;
						if (t > 64'hFFFFFF)
							t = 64'hFFFFFF;
						if (t < 64'(base_rtt))
							base_rtt = t[23:0];
						if (t > 64'(peak_rtt))
							peak_rtt = t[23:0];
						latest_rtt = t[23:0];
						sample_seen = 1'b1;
					end
					if (cwnd <= ssthresh) begin
						if (cwnd < clamp)
							cwnd++;
					end else begin
						if (sample_seen) begin
							d = (latest_rtt != 0) ? 64'(latest_rtt) : 64'd1;
							w = int_root((64'(peak_rtt) * 64'(cwnd)) / d);
						end else begin
							w = 64'd1;
						end
						c = 64'(credit) + w;
						if (c > 64'hFFFFFF)
							c = 64'hFFFFFF;
						win = 64'(cwnd);
						while (win < 64'(clamp) && c >= win) begin
							c -= win;
							win++;
						end
						if (c >= win)
							c = c % win;
						cwnd = win[15:0];
						credit = c[23:0];
					end
				end
				ecw_pkg::OP_LOSS: begin
					t = (64'd7 * 64'(cwnd)) >> 3;
					t = (t >= 64'd3) ? t - 64'd1 : 64'd2;
					ssthresh = t[15:0];
					t = t + 64'd1;
					if (t > 64'(clamp))
						t = 64'(clamp);
					cwnd = t[15:0];
				end
				ecw_pkg::OP_RESTART: begin
					base_rtt = 24'hFFFFFF;
					peak_rtt = '0;
				end
				default: ;
			endcase
			e.window = cwnd;
			e.threshold = ssthresh;
			e.weight_factor = w[19:0];
			e.base_delay = base_rtt;
			e.peak_delay = peak_rtt;
			pending.push_back(e);
		endfunction

		function void compare(string name, bit [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check(ecw_pkg::out_item_t got);
			ecw_pkg::out_item_t e;
			if (pending.size() == 0) begin
				$error("result beat with nothing outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			compare("window", 64'(e.window), 64'(got.window));
			compare("threshold", 64'(e.threshold), 64'(got.threshold));
			compare("weight_factor", 64'(e.weight_factor), 64'(got.weight_factor));
			compare("base_delay", 64'(e.base_delay), 64'(got.base_delay));
			compare("peak_delay", 64'(e.peak_delay), 64'(got.peak_delay));
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	ecw_pkg::in_item_t       in_data = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	ecw_pkg::out_item_t      out_data;
	logic                    cfg_we = 1'b0;
	logic [ecw_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [ecw_pkg::CFG_BITS-1:0]     cfg_data = '0;

	window_scoreboard sb = new();
	bit  steady;
	int  received;
	int  quiet;

	elastic_congestion_window dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function ecw_pkg::in_item_t make_beat(logic [1:0] op, logic sv, logic [23:0] rtt);
		ecw_pkg::in_item_t x;
		x.operation = op;
		x.sample_valid = sv;
		x.rtt_us = rtt;
		return x;
	endfunction

	function ecw_pkg::in_item_t random_beat();
		int r;
		logic [23:0] rtt;
		logic [1:0] op;
		r = $urandom_range(0, 99);
		if (r < 80)
			op = ecw_pkg::OP_ACK;
		else if (r < 90)
			op = ecw_pkg::OP_LOSS;
		else if (r < 97)
			op = ecw_pkg::OP_RESTART;
		else
			op = ecw_pkg::OP_NONE;
		r = $urandom_range(0, 9);
		if (r < 6)
			rtt = 24'($urandom_range(500, 8000));
		else if (r < 9)
			rtt = 24'($urandom());
		else
			rtt = 24'($urandom_range(24'hFFFFF0, 24'hFFFFFF));
		return make_beat(op, ($urandom_range(0, 9) < 7), rtt);
	endfunction

	task automatic send(ecw_pkg::in_item_t x);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= x;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note(x);
	endtask

	task automatic program_regs(bit [15:0] w, bit [15:0] t, bit [15:0] c);
		cfg_we <= 1'b1;
		cfg_index <= ecw_pkg::REG_INITIAL_WINDOW;
		cfg_data <= w;
		@(posedge clk);
		sb.write_reg(ecw_pkg::REG_INITIAL_WINDOW, w);
		cfg_index <= ecw_pkg::REG_INITIAL_THRESHOLD;
		cfg_data <= t;
		@(posedge clk);
		sb.write_reg(ecw_pkg::REG_INITIAL_THRESHOLD, t);
		cfg_index <= ecw_pkg::REG_WINDOW_CLAMP;
		cfg_data <= c;
		@(posedge clk);
		sb.write_reg(ecw_pkg::REG_WINDOW_CLAMP, c);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Receiver: random stalls, plus one long hold so the block backs up its input.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = (received == 300) ? 3000 : pick_gap();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			sb.check(out_data);
			received++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 200000) begin
			$display("elastic_congestion_window: mismatch");
			$finish;
		end
	end

	initial begin
		bit [15:0] win_set[5], thr_set[5], clamp_set[5];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: slow start, sample extremes, loss into avoidance, unused op.
		send(make_beat(ecw_pkg::OP_ACK, 1'b0, 24'd0));
		send(make_beat(ecw_pkg::OP_ACK, 1'b1, 24'd0));
		send(make_beat(ecw_pkg::OP_ACK, 1'b1, 24'd16777214));
		send(make_beat(ecw_pkg::OP_ACK, 1'b1, 24'hFFFFFF));
		send(make_beat(ecw_pkg::OP_NONE, 1'b1, 24'd77));
		send(make_beat(ecw_pkg::OP_LOSS, 1'b1, 24'd5));
		send(make_beat(ecw_pkg::OP_RESTART, 1'b1, 24'h5A5A5A));
		send(make_beat(ecw_pkg::OP_ACK, 1'b0, 24'hA5A5A5));
		send(make_beat(ecw_pkg::OP_ACK, 1'b1, 24'd1));
		send(make_beat(ecw_pkg::OP_ACK, 1'b1, 24'd16777214));
		send(make_beat(ecw_pkg::OP_ACK, 1'b1, 24'd0));
		send(make_beat(ecw_pkg::OP_LOSS, 1'b0, 24'd0));
		send(make_beat(ecw_pkg::OP_LOSS, 1'b0, 24'd0));
		send(make_beat(ecw_pkg::OP_ACK, 1'b1, 24'd3000));
		send(make_beat(ecw_pkg::OP_ACK, 1'b0, 24'd0));
		send(make_beat(ecw_pkg::OP_RESTART, 1'b0, 24'd0));
		send(make_beat(ecw_pkg::OP_ACK, 1'b0, 24'd0));
		send(make_beat(ecw_pkg::OP_ACK, 1'b1, 24'd2000));
		drain();

		win_set   = '{16'd2, 16'd1, 16'd65535, 16'd300, 16'd17};
		thr_set   = '{16'd65535, 16'd2, 16'd65535, 16'd100, 16'd40};
		clamp_set = '{16'd65535, 16'd40, 16'd2, 16'd65535, 16'd12};
		for (int p = 0; p < 5; p++) begin
			if (p > 0)
				program_regs(win_set[p], thr_set[p], clamp_set[p]);
			steady = (p == 3);
			for (int i = 0; i < 226; i++)
				send(random_beat());
			drain();
		end

		if (sb.errors == 0)
			$display("elastic_congestion_window: match");
		else
			$display("elastic_congestion_window: mismatch");
		$finish;
	end
endmodule

// File: sim.f
sv/ecw_pkg.sv
sv/ecw_datapath.sv
sv/ecw_controller.sv
sv/elastic_congestion_window.sv
dv/tb_elastic_congestion_window.sv
